// ===== hdl/mlft_pkg.sv =====
// Package for the MAC learning forwarding table.
// Sizes, field widths, codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none
package mlft_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int NUM_PORTS     = 4;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int PORT_W  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    localparam int FUNC_W   = 2;
    localparam int INPORT_W = 4;
    localparam int MAC_W    = 48;
    localparam int KIND_W   = 2;
    localparam int AGED_W   = 13;
    localparam int EXP_W    = 32;
    localparam int LIFE_W   = 16;
    localparam int FP_W     = INPORT_W + 1;
    localparam int ENT_W    = MAC_W + PORT_W + EXP_W;

    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 24;

    localparam logic [LIFE_W-1:0] LIFE_RESET = 16'd10;

    localparam logic [FUNC_W-1:0] FUNC_PKT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SWEEP = 2'd2;

    localparam logic [KIND_W-1:0] KIND_FORWARD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLOOD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SWEEP   = 2'd2;

    typedef struct packed {
        logic load;
        logic tick;
        logic scan;
        logic learn_wr;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0]   in_func;
        logic                in_port_ok;
        logic                is_pkt;
        logic                scan_done;
        logic                out_free;
        logic                emit_last;
    } t_status;

endpackage
`default_nettype wire

// ===== hdl/mac_learning_forwarding_table_unit.sv =====
// Top level of the MAC learning forwarding table.
// Depends on mlft_pkg, mlft_ctrl, mlft_dpath (which holds mlft_ram).
//
// Items are taken one at a time. A tick is done without leaving the idle state. A packet
// or an aging sweep walks the entry RAM one address per cycle through its single read
// port before its first result, a packet then has a learn write step, and the results
// follow one per cycle (up to NUM_PORTS - 1 flooded copies) as the output side takes
// them. The next item is taken once the final result sits in the output register. No
// clearing pass is needed after reset.
`default_nettype none
module mac_learning_forwarding_table_unit import mlft_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [LIFE_W-1:0]   i_cfg_wr_data,   // mac_lifetime
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,       // in_port, src_mac, dst_mac, pad
    input  wire logic [FUNC_W-1:0]   i_s_tuser,       // func
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [M_DATA_W-1:0]      o_m_tdata,       // out_port, aged_count, pad
    output logic [KIND_W-1:0]        o_m_tuser,       // result_kind
    output logic                     o_m_tlast
);
    t_cmd    cmd;
    t_status stat;

    mlft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_stat  (stat),
        .o_ready (o_s_tready),
        .o_cmd   (cmd)
    );

    mlft_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tready    (i_m_tready),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

    a_sweep_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_SWEEP) |-> o_m_tlast)
        else $error("sweep report without last");

    a_fwd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_FORWARD) |-> o_m_tlast)
        else $error("unicast forward without last");

    a_port_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[INPORT_W-1:0] < INPORT_W'(NUM_PORTS)))
        else $error("output port out of range");
endmodule
`default_nettype wire

// ===== hdl/mlft_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module mlft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/mlft_ctrl.sv =====
// Controller state machine for the MAC table: sequences scan, learn write and emission.
// Depends on mlft_pkg.
`default_nettype none
module mlft_ctrl import mlft_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_status i_stat,
    output logic         o_ready,
    output t_cmd         o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LWR  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_stat.in_func)
                        FUNC_TICK: o_cmd.tick = 1'b1;
                        FUNC_PKT: begin
                            if (i_stat.in_port_ok) begin
                                o_cmd.load = 1'b1;
                                n_state    = S_SCAN;
                            end
                        end
                        FUNC_SWEEP: begin
                            o_cmd.load = 1'b1;
                            n_state    = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = i_stat.is_pkt ? S_LWR : S_EMIT;
                end
            end
            S_LWR: begin
                o_cmd.learn_wr = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/mlft_dpath.sv =====
// Datapath for the MAC table: entry RAM, valid bits, scan compare, clock, output register.
// Depends on mlft_pkg and mlft_ram.
`default_nettype none
module mlft_dpath import mlft_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [LIFE_W-1:0]   i_cfg_wr_data,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    input  wire logic [FUNC_W-1:0]   i_s_tuser,
    input  wire logic                i_m_tready,
    input  wire t_cmd                i_cmd,
    output t_status                  o_stat,
    output logic                     o_m_tvalid,
    output logic [M_DATA_W-1:0]      o_m_tdata,
    output logic [KIND_W-1:0]        o_m_tuser,
    output logic                     o_m_tlast
);
    logic [FUNC_W-1:0]   r_func;
    logic [INPORT_W-1:0] r_port;
    logic [MAC_W-1:0]    r_src, r_dst;
    logic [LIFE_W-1:0]   r_life;
    logic [EXP_W-1:0]    r_now;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_chk_vld;
    logic [IDX_W-1:0]    r_chk_idx;
    logic                r_m_found, r_f_found, r_h_found;
    logic [IDX_W-1:0]    r_m_idx, r_f_idx;
    logic [PORT_W-1:0]   r_h_port;
    logic [ADDR_W-1:0]   r_aged;
    logic [FP_W-1:0]     r_fp;
    logic                r_o_valid;
    logic [INPORT_W-1:0] r_o_port;
    logic [AGED_W-1:0]   r_o_aged;
    logic [KIND_W-1:0]   r_o_kind;
    logic                r_o_last;

    logic [ENT_W-1:0]  rd_data;
    logic [MAC_W-1:0]  e_mac;
    logic [PORT_W-1:0] e_port;
    logic [EXP_W-1:0]  e_exp;
    logic              e_vld;
    logic [EXP_W:0]    exp_sum;
    logic [EXP_W-1:0]  exp_new;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic              issue;
    logic [FP_W-1:0]   port_ext, fp_cur, fp_last;
    logic              out_free, emit_last;

    assign e_mac  = rd_data[MAC_W-1:0];
    assign e_port = rd_data[MAC_W +: PORT_W];
    assign e_exp  = rd_data[MAC_W+PORT_W +: EXP_W];
    assign e_vld  = r_valid[r_chk_idx];

    assign exp_sum = {1'b0, r_now} + (EXP_W+1)'(r_life);
    assign exp_new = exp_sum[EXP_W] ? '1 : exp_sum[EXP_W-1:0];

    assign issue     = i_cmd.scan && (r_addr != ADDR_W'(TABLE_ENTRIES));
    assign ram_we    = i_cmd.learn_wr && (r_m_found || r_f_found);
    assign ram_waddr = r_m_found ? r_m_idx : r_f_idx;

    mlft_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({exp_new, r_port[PORT_W-1:0], r_src}),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    // flood walk skips the arrival port
    assign port_ext = FP_W'(r_port);
    assign fp_cur   = (r_fp == port_ext) ? r_fp + 1'b1 : r_fp;
    assign fp_last  = (port_ext == FP_W'(NUM_PORTS - 1)) ? FP_W'(NUM_PORTS - 2)
                                                         : FP_W'(NUM_PORTS - 1);
    assign out_free  = !r_o_valid || i_m_tready;
    assign emit_last = (r_func != FUNC_PKT) || r_h_found || (fp_cur == fp_last);

    always_comb begin
        o_stat            = '0;
        o_stat.in_func    = i_s_tuser;
        o_stat.in_port_ok = (FP_W'(i_s_tdata[INPORT_W-1:0]) < FP_W'(NUM_PORTS));
        o_stat.is_pkt     = (r_func == FUNC_PKT);
        o_stat.scan_done  = (r_addr == ADDR_W'(TABLE_ENTRIES)) && !r_chk_vld;
        o_stat.out_free   = out_free;
        o_stat.emit_last  = emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life    <= LIFE_RESET;
            r_now     <= '0;
            r_valid   <= '0;
            r_addr    <= '0;
            r_chk_vld <= 1'b0;
            r_m_found <= 1'b0;
            r_f_found <= 1'b0;
            r_h_found <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_life <= i_cfg_wr_data;
            end
            if (i_cmd.tick && (r_now != '1)) begin
                r_now <= r_now + 1'b1;
            end
            if (i_cmd.load) begin
                r_addr    <= '0;
                r_m_found <= 1'b0;
                r_f_found <= 1'b0;
                r_h_found <= 1'b0;
            end else if (issue) begin
                r_addr <= r_addr + 1'b1;
            end
            r_chk_vld <= issue;
            if (r_chk_vld) begin
                if (r_func == FUNC_PKT) begin
                    if (e_vld && (e_mac == r_src) && !r_m_found) begin
                        r_m_found <= 1'b1;
                    end
                    if (!e_vld && !r_f_found) begin
                        r_f_found <= 1'b1;
                    end
                    // the source's own entry moves to the arrival port, so never a hit
                    if (e_vld && (e_port != r_port[PORT_W-1:0]) && (e_mac == r_dst)
                        && (e_mac != r_src) && !r_h_found) begin
                        r_h_found <= 1'b1;
                    end
                end else if (e_vld && (r_now > e_exp)) begin
                    r_valid[r_chk_idx] <= 1'b0;
                end
            end
            if (i_cmd.learn_wr && !r_m_found && r_f_found) begin
                r_valid[r_f_idx] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_s_tuser;
            r_port <= i_s_tdata[INPORT_W-1:0];
            r_src  <= i_s_tdata[INPORT_W +: MAC_W];
            r_dst  <= i_s_tdata[INPORT_W+MAC_W +: MAC_W];
            r_aged <= '0;
            r_fp   <= '0;
        end
        if (issue) begin
            r_chk_idx <= r_addr[IDX_W-1:0];
        end
        if (r_chk_vld) begin
            if (r_func == FUNC_PKT) begin
                if (e_vld && (e_mac == r_src) && !r_m_found) begin
                    r_m_idx <= r_chk_idx;
                end
                if (!e_vld && !r_f_found) begin
                    r_f_idx <= r_chk_idx;
                end
                if (e_vld && (e_port != r_port[PORT_W-1:0]) && (e_mac == r_dst)
                    && (e_mac != r_src) && !r_h_found) begin
                    r_h_port <= e_port;
                end
            end else if (e_vld && (r_now > e_exp)) begin
                r_aged <= r_aged + 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_o_last <= emit_last;
            if (r_func != FUNC_PKT) begin
                r_o_kind <= KIND_SWEEP;
                r_o_port <= '0;
                r_o_aged <= AGED_W'(r_aged);
            end else if (r_h_found) begin
                r_o_kind <= KIND_FORWARD;
                r_o_port <= INPORT_W'(r_h_port);
                r_o_aged <= '0;
            end else begin
                r_o_kind <= KIND_FLOOD;
                r_o_port <= fp_cur[INPORT_W-1:0];
                r_o_aged <= '0;
                r_fp     <= fp_cur + 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{(M_DATA_W-INPORT_W-AGED_W){1'b0}}, r_o_aged, r_o_port};
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;
endmodule
`default_nettype wire
